// ===== rtl/qnmra_pkg.sv =====
// Shared types, constants and control structs for the quantized neuron engine.
package qnmra_pkg;

    localparam int unsigned INDEX_WIDTH_DEF = 16;
    localparam int unsigned ACC_WIDTH_DEF   = 32;
    localparam int unsigned DATA_WIDTH      = 32;
    localparam int unsigned CFG_WIDTH       = 31;
    localparam int unsigned CFG_ADDR_WIDTH  = 2;
    localparam int unsigned OUT_INDEX_WIDTH = 16;

    localparam logic [CFG_ADDR_WIDTH-1:0] REG_IN_SCALE       = 2'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_OUT_SCALE      = 2'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_RESULT_DIVISOR = 2'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_RELU_ENABLE    = 2'd3;

    localparam logic [15:0] IN_SCALE_RESET       = 16'd1000;
    localparam logic [15:0] OUT_SCALE_RESET      = 16'd1000;
    localparam logic [30:0] RESULT_DIVISOR_RESET = 31'd1000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_DIV1,
        ST_MUL2,
        ST_ACC,
        ST_DIV2,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic mul1;
        logic div_start;
        logic div_sel_final;
        logic mul2;
        logic acc;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic term_last;
    } status_t;

endpackage

// ===== rtl/qnmra_divider.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module qnmra_divider #(
    parameter int unsigned WIDTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient
);

    localparam int unsigned CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dvs_reg, dvs_next;
    logic             neg_reg, neg_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH:0]   trial;
    logic [WIDTH-1:0] shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[WIDTH-2:0], quo_reg[WIDTH-1]};
        trial     = {1'b0, shifted} - {1'b0, dvs_reg};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend[WIDTH-1] ? (~dividend + 1'b1) : dividend;
            dvs_next  = divisor[WIDTH-1] ? (~divisor + 1'b1) : divisor;
            neg_next  = dividend[WIDTH-1] ^ divisor[WIDTH-1];
            cnt_next  = CW'(WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[WIDTH])
            begin
                rem_next = trial[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

// ===== rtl/qnmra_datapath.sv =====
// Datapath: scaling, accumulate, final divide, ReLU and running argmax.
module qnmra_datapath #(
    parameter int unsigned INDEX_WIDTH = qnmra_pkg::INDEX_WIDTH_DEF,
    parameter int unsigned ACC_WIDTH   = qnmra_pkg::ACC_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  qnmra_pkg::cmd_t         cmd,
    output qnmra_pkg::status_t      status,
    input  logic [15:0]             in_scale_cfg,
    input  logic [15:0]             out_scale_cfg,
    input  logic [30:0]             result_divisor_cfg,
    input  logic                    relu_cfg,
    input  logic signed [31:0]      activation,
    input  logic signed [31:0]      weight,
    input  logic signed [31:0]      bias,
    input  logic                    term_last,
    input  logic                    layer_last,
    output logic signed [31:0]      neuron_value,
    output logic [15:0]             neuron_index,
    output logic [15:0]             best_label,
    output logic                    label_valid
);

    localparam int unsigned DW = 64;

    logic [31:0]            act_reg, wgt_reg, bias_reg;
    logic                   tlast_reg, llast_reg;
    logic [DW-1:0]          prod_reg, scaled_reg;
    logic [ACC_WIDTH-1:0]   acc_reg, acc_next;
    logic [INDEX_WIDTH-1:0] cnt_reg, cnt_next;
    logic signed [31:0]     best_val_reg;
    logic [INDEX_WIDTH-1:0] best_idx_reg;
    logic signed [31:0]     out_val_reg;
    logic [15:0]            out_idx_reg, out_best_reg;
    logic                   out_last_reg;
    logic                   div_done;
    logic [DW-1:0]          div_q, div_a, div_b;
    logic [ACC_WIDTH-1:0]   term, bias_term;
    logic signed [31:0]     val;
    logic signed [DW-1:0]   qs;
    logic signed [48:0]     act_prod;

    assign div_a = cmd.div_sel_final
        ? DW'($signed(acc_reg)) : prod_reg;
    assign div_b = cmd.div_sel_final
        ? ((result_divisor_cfg == '0) ? DW'(1) : DW'(result_divisor_cfg))
        : ((in_scale_cfg == '0) ? DW'(1) : DW'(in_scale_cfg));

    qnmra_divider #(.WIDTH(DW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign act_prod  = $signed(act_reg) * $signed({1'b0, out_scale_cfg});
    assign term      = ACC_WIDTH'(scaled_reg[ACC_WIDTH-1:0] * ACC_WIDTH'($signed(wgt_reg)));
    assign bias_term = ACC_WIDTH'($signed(bias_reg)) * ACC_WIDTH'(out_scale_cfg);
    assign status.div_done  = div_done;
    assign status.term_last = tlast_reg;

    always_comb
    begin
        qs = $signed(div_q);
        if (qs > 64'sd2147483647)
            val = 32'sh7fffffff;
        else if (qs < -64'sd2147483648)
            val = 32'sh80000000;
        else
            val = div_q[31:0];
        if (relu_cfg && val <= 0)
            val = '0;
        acc_next = acc_reg;
        if (cmd.acc)
            acc_next = acc_reg + term;
        if (cmd.mul2)
            acc_next = acc_reg + bias_term;
        if (cmd.finish)
            acc_next = '0;
        cnt_next = llast_reg ? '0 : cnt_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            cnt_reg      <= '0;
            best_val_reg <= '0;
            best_idx_reg <= '0;
            out_val_reg  <= '0;
            out_idx_reg  <= '0;
            out_best_reg <= '0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (cmd.finish)
            begin
                if (cnt_reg == '0 || val > best_val_reg)
                begin
                    best_val_reg <= val;
                    best_idx_reg <= cnt_reg;
                    out_best_reg <= 16'(cnt_reg);
                end
                else
                    out_best_reg <= 16'(best_idx_reg);
                out_val_reg  <= val;
                out_idx_reg  <= 16'(cnt_reg);
                out_last_reg <= llast_reg;
                cnt_reg      <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= activation;
            wgt_reg   <= weight;
            bias_reg  <= bias;
            tlast_reg <= term_last;
            llast_reg <= layer_last;
        end
        if (cmd.mul1)
            prod_reg <= DW'(act_prod);
        if (div_done && !cmd.div_sel_final)
            scaled_reg <= div_q;
    end

    assign neuron_value = out_val_reg;
    assign neuron_index = out_idx_reg;
    assign best_label   = out_best_reg;
    assign label_valid  = out_last_reg;

endmodule

// ===== rtl/qnmra_ctrl.sv =====
// Controller state machine sequencing one transfer through the datapath.
module qnmra_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               out_stall,
    input  qnmra_pkg::status_t status,
    output qnmra_pkg::cmd_t    cmd
);

    qnmra_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= qnmra_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            qnmra_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = qnmra_pkg::ST_MUL1;
                end
            end
            qnmra_pkg::ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = qnmra_pkg::ST_DIV1;
            end
            qnmra_pkg::ST_DIV1:
            begin
                cmd.div_start = 1'b1;
                state_next    = qnmra_pkg::ST_MUL2;
            end
            qnmra_pkg::ST_MUL2:
            begin
                if (status.div_done)
                    state_next = qnmra_pkg::ST_ACC;
            end
            qnmra_pkg::ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (status.term_last)
                    state_next = qnmra_pkg::ST_DIV2;
                else
                    state_next = qnmra_pkg::ST_IDLE;
            end
            qnmra_pkg::ST_DIV2:
            begin
                cmd.mul2   = 1'b1;
                state_next = qnmra_pkg::ST_FINISH;
            end
            qnmra_pkg::ST_FINISH:
            begin
                // wait until the result register is free or being taken
                cmd.div_sel_final = 1'b1;
                if (!out_stall)
                begin
                    if (!status.div_done)
                        cmd.div_start = 1'b1;
                    state_next = qnmra_pkg::ST_OUT;
                end
            end
            qnmra_pkg::ST_OUT:
            begin
                cmd.div_sel_final = 1'b1;
                if (status.div_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = qnmra_pkg::ST_IDLE;
                end
            end
            default: state_next = qnmra_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/quantized_neuron_mac_relu_argmax.sv =====
// Top level of the quantized neuron engine.
// Quantized neuron engine: each transfer adds ((activation*out_scale)/in_scale)*weight to
// a wrapping accumulator; the term marked last adds bias*out_scale, divides by
// result_divisor, optionally rectifies and updates a running argmax. One transfer at a
// time, paced by the 64-bit radix-2 divider shared between the scaling and the final
// divide; a last term also waits before its final divide while an untaken result holds
// the output register.
module quantized_neuron_mac_relu_argmax #(
    parameter int unsigned INDEX_WIDTH = qnmra_pkg::INDEX_WIDTH_DEF,
    parameter int unsigned ACC_WIDTH   = qnmra_pkg::ACC_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] activation,
    input  logic signed [31:0] weight,
    input  logic signed [31:0] bias,
    input  logic               term_last,
    input  logic               layer_last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] neuron_value,
    output logic [15:0]        neuron_index,
    output logic [15:0]        best_label,
    output logic               label_valid
);

    logic [15:0] in_scale_reg, out_scale_reg;
    logic [30:0] result_divisor_reg;
    logic        relu_reg;
    logic        ov_reg;
    logic        ctl_in_stall;
    qnmra_pkg::cmd_t    cmd;
    qnmra_pkg::status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_scale_reg       <= qnmra_pkg::IN_SCALE_RESET;
            out_scale_reg      <= qnmra_pkg::OUT_SCALE_RESET;
            result_divisor_reg <= qnmra_pkg::RESULT_DIVISOR_RESET;
            relu_reg           <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                qnmra_pkg::REG_IN_SCALE:       in_scale_reg       <= cfg_data[15:0];
                qnmra_pkg::REG_OUT_SCALE:      out_scale_reg      <= cfg_data[15:0];
                qnmra_pkg::REG_RESULT_DIVISOR: result_divisor_reg <= cfg_data;
                qnmra_pkg::REG_RELU_ENABLE:    relu_reg           <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // result register: holds until taken; controller waits while it is full and not being taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.finish)
            ov_reg <= 1'b1;
        else if (!out_stall)
            ov_reg <= 1'b0;
    end

    assign out_valid = ov_reg;
    assign in_stall  = ctl_in_stall;

    qnmra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (ctl_in_stall),
        .out_stall (ov_reg && out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    qnmra_datapath #(
        .INDEX_WIDTH (INDEX_WIDTH),
        .ACC_WIDTH   (ACC_WIDTH)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .in_scale_cfg       (in_scale_reg),
        .out_scale_cfg      (out_scale_reg),
        .result_divisor_cfg (result_divisor_reg),
        .relu_cfg           (relu_reg),
        .activation         (activation),
        .weight             (weight),
        .bias               (bias),
        .term_last          (term_last),
        .layer_last         (layer_last),
        .neuron_value       (neuron_value),
        .neuron_index       (neuron_index),
        .best_label         (best_label),
        .label_valid        (label_valid)
    );

endmodule

// ===== tb/tb_qnmra_checker.sv =====
// Checker: watches both channels, predicts neuron results and compares them.
`timescale 1ns / 100ps
module tb_qnmra_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [31:0] activation,
    input  logic signed [31:0] weight,
    input  logic signed [31:0] bias,
    input  logic               term_last,
    input  logic               layer_last,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] neuron_value,
    input  logic [15:0]        neuron_index,
    input  logic [15:0]        best_label,
    input  logic               label_valid,
    output int                 fail_count,
    output int                 pending,
    output int                 results_seen
);

    typedef struct packed {
        logic signed [31:0] value;
        logic [15:0]        index;
        logic [15:0]        label;
        logic               closes;
    } neuron_t;

    logic [15:0] m_in_scale, m_out_scale;
    logic [30:0] m_divisor;
    logic        m_relu;
    logic [31:0] m_acc;
    logic [15:0] m_count, m_best_idx;
    logic signed [31:0] m_best_val;
    neuron_t     expected_neurons[$];

    assign pending = expected_neurons.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        fail_count++;
        $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, exp, results_seen);
    endtask

    task automatic predict_neuron();
        longint act, scaled, isc, sv, q;
        logic [31:0] term, sum;
        logic signed [31:0] val;
        neuron_t n;
        act = longint'(activation);
        isc = (m_in_scale == 0) ? 1 : longint'(m_in_scale);
        scaled = (act * longint'(m_out_scale)) / isc;
        term = 32'(scaled * longint'(weight));
        sum = m_acc + term;
        if (!term_last) begin
            m_acc = sum;
            return;
        end
        sum = sum + 32'(longint'(bias) * longint'(m_out_scale));
        sv = longint'($signed(sum));
        q = sv / ((m_divisor == 0) ? 1 : longint'(m_divisor));
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        val = 32'(q);
        if (m_relu && val <= 0) val = 0;
        if (m_count == 0 || val > m_best_val) begin
            m_best_val = val;
            m_best_idx = m_count;
        end
        n.value = val;
        n.index = m_count;
        n.label = m_best_idx;
        n.closes = layer_last;
        expected_neurons.push_back(n);
        m_acc = 0;
        m_count = layer_last ? 16'd0 : m_count + 16'd1;
    endtask

    always @(posedge clk or negedge rst_n) begin
        neuron_t e;
        if (!rst_n) begin
            m_in_scale = qnmra_pkg::IN_SCALE_RESET;
            m_out_scale = qnmra_pkg::OUT_SCALE_RESET;
            m_divisor = qnmra_pkg::RESULT_DIVISOR_RESET;
            m_relu = 1'b1;
            m_acc = 0;
            m_count = 0;
            m_best_val = 0;
            m_best_idx = 0;
            expected_neurons.delete();
            fail_count = 0;
            results_seen = 0;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    qnmra_pkg::REG_IN_SCALE:       m_in_scale = cfg_data[15:0];
                    qnmra_pkg::REG_OUT_SCALE:      m_out_scale = cfg_data[15:0];
                    qnmra_pkg::REG_RESULT_DIVISOR: m_divisor = cfg_data;
                    qnmra_pkg::REG_RELU_ENABLE:    m_relu = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (expected_neurons.size() == 0) begin
                    report("unexpected result transfer", neuron_value, '0);
                end else begin
                    e = expected_neurons.pop_front();
                    if (neuron_value !== e.value) report("neuron_value", neuron_value, e.value);
                    if (neuron_index !== e.index) report("neuron_index", neuron_index, e.index);
                    if (best_label !== e.label) report("best_label", best_label, e.label);
                    if (label_valid !== e.closes) report("label_valid", label_valid, e.closes);
                end
                results_seen++;
            end
            if (in_valid && !in_stall) predict_neuron();
        end
    end
endmodule

// ===== tb/tb_quantized_neuron_mac_relu_argmax.sv =====
// Testbench top: clock, reset, configuration phases, stimulus and verdict.
`timescale 1ns / 100ps
module tb_quantized_neuron_mac_relu_argmax;

    logic clk, rst_n;
    logic cfg_write;
    logic [1:0] cfg_index;
    logic [30:0] cfg_data;
    logic in_valid, in_stall, out_valid, out_stall;
    logic signed [31:0] activation, weight, bias, neuron_value;
    logic term_last, layer_last, label_valid;
    logic [15:0] neuron_index, best_label;
    int fail_count, pending, results_seen;
    int items_sent, idle_cycles, layers_closed;
    bit hold_off;

    quantized_neuron_mac_relu_argmax u_dut (.*);

    tb_qnmra_checker u_chk (.*);

    initial clk = 0;
    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    // Receiver: random stalls, plus one long hold-off.
    always @(posedge clk or negedge rst_n) begin
        int wait_left;
        if (!rst_n) begin
            out_stall <= 1'b1;
            wait_left = 0;
        end else if (hold_off) begin
            out_stall <= 1'b1;
        end else if (out_valid && !out_stall) begin
            wait_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            out_stall <= (wait_left != 0);
        end else if (wait_left > 0) begin
            wait_left--;
            out_stall <= (wait_left != 0);
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (out_valid && !out_stall && label_valid) layers_closed++;
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic send_term(input logic signed [31:0] a, input logic signed [31:0] w,
                             input logic signed [31:0] b, input logic tl, input logic ll,
                             input bit no_gap);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5));
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        activation <= a;
        weight <= w;
        bias <= b;
        term_last <= tl;
        layer_last <= ll;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    function automatic logic signed [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 20)) - 10;
            3: return $signed($urandom_range(0, 4000)) - 2000;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_layer(input int neurons, input int terms);
        for (int n = 0; n < neurons; n++) begin
            for (int t = 0; t < terms; t++)
                send_term(rnd_word(), rnd_word(), rnd_word(), t == terms - 1,
                          (t == terms - 1) ? (n == neurons - 1) : $urandom_range(0, 1), 0);
        end
    endtask

    initial begin
        rst_n = 0;
        cfg_write = 0;
        cfg_index = qnmra_pkg::REG_IN_SCALE;
        cfg_data = 0;
        in_valid = 0;
        activation = 0;
        weight = 0;
        bias = 0;
        term_last = 0;
        layer_last = 0;
        hold_off = 0;
        items_sent = 0;
        layers_closed = 0;
        idle_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: reset settings, extremes, ties, stray layer end.
        send_term(32'sd2000, 32'sd3, 32'sd0, 0, 1, 0);
        send_term(32'sd1000, 32'sd1, 32'sd5, 1, 0, 0);
        send_term(32'sd1000, 32'sd4, 32'sd0, 1, 0, 0);
        send_term(32'sd1000, 32'sd4, 32'sd0, 1, 0, 0);
        send_term(-32'sd1000, 32'sd9, 32'sd0, 1, 1, 0);
        send_term(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1, 0, 0);
        send_term(32'sh80000000, 32'sh80000000, 32'sh80000000, 1, 0, 0);
        send_term(32'shffffffff, 32'sh80000000, 32'sh7fffffff, 1, 1, 0);
        drain();
        write_reg(qnmra_pkg::REG_RELU_ENABLE, 31'd0);
        write_reg(qnmra_pkg::REG_RESULT_DIVISOR, 31'd1);
        write_reg(qnmra_pkg::REG_IN_SCALE, 31'd1);
        write_reg(qnmra_pkg::REG_OUT_SCALE, 31'd65535);
        send_term(-32'sd7, 32'sd3, -32'sd1, 1, 0, 0);
        send_term(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1, 0, 0);
        send_term(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1, 0, 0);
        send_term(-32'sd5, 32'sd1, 32'sd0, 1, 1, 0);
        drain();
        write_reg(qnmra_pkg::REG_IN_SCALE, 31'd65535);
        write_reg(qnmra_pkg::REG_OUT_SCALE, 31'd1);
        write_reg(qnmra_pkg::REG_RESULT_DIVISOR, 31'h7fffffff);
        send_term(32'sh7fffffff, 32'sd1, 32'sh7fffffff, 1, 0, 0);
        send_term(-32'sd65534, 32'sd1, 32'sh80000000, 1, 1, 0);
        drain();

        // Pressure: receiver holds off while the sender keeps offering.
        write_reg(qnmra_pkg::REG_IN_SCALE, 31'd1000);
        write_reg(qnmra_pkg::REG_OUT_SCALE, 31'd1000);
        write_reg(qnmra_pkg::REG_RESULT_DIVISOR, 31'd1000);
        write_reg(qnmra_pkg::REG_RELU_ENABLE, 31'd1);
        hold_off = 1;
        fork
            begin
                repeat (2000) @(posedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 6; i++) send_term(rnd_word(), rnd_word(), rnd_word(), 1, 0, 1);
        join
        send_term(0, 0, 0, 1, 1, 0);
        drain();

        // Random phases over several settings.
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(qnmra_pkg::REG_IN_SCALE, (ph == 0) ? 31'd1 : (ph == 1) ? 31'd65535 :
                      31'($urandom_range(1, 65535)));
            write_reg(qnmra_pkg::REG_OUT_SCALE, (ph == 2) ? 31'd1 : (ph == 3) ? 31'd65535 :
                      31'($urandom_range(1, 3000)));
            write_reg(qnmra_pkg::REG_RESULT_DIVISOR, (ph == 4) ? 31'd1 :
                      (ph == 5) ? 31'h7fffffff :
                      (ph[0] ? 31'($urandom_range(1, 1000000)) : 31'($urandom)));
            write_reg(qnmra_pkg::REG_RELU_ENABLE, 31'(ph[0]));
            while (items_sent < 60 + ph * 65)
                random_layer($urandom_range(1, 8), $urandom_range(1, 4));
            drain();
        end
        // Long layer to move the index upper bits.
        write_reg(qnmra_pkg::REG_RELU_ENABLE, 31'd0);
        random_layer(300, 1);
        drain();

        $display("sent %0d terms, checked %0d neuron results, %0d layers closed",
                 items_sent, results_seen, layers_closed);
        $display("covered scale and divisor extremes, relu on/off, receiver hold-off");
        if (fail_count == 0 && pending == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
